@@ rtl/cosine_distance_stream_defines.svh @@
// assertion macros shared by the cosine distance checker
`ifndef COSINE_DISTANCE_STREAM_DEFINES_SVH
`define COSINE_DISTANCE_STREAM_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cds_pkg.sv @@
// types and constants of the cosine distance stream block
`timescale 1ns / 1ps
package cds_pkg;

  localparam int DOT_W   = 42;   // dot product accumulator
  localparam int NORM_W  = 41;   // squared norm accumulators
  localparam int LIMB_W  = 32;   // limb fed to the shared multiplier
  localparam int MUL_W   = 33;   // signed multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int P_W     = 2 * NORM_W;      // norm_a * norm_b
  localparam int WIDE_W  = 114;             // wide product / compare width
  localparam int T2_W    = 30;              // (2m-1)^2
  localparam int RES_W   = 15;              // cosine magnitude 0..16384
  localparam int DIST_W  = 16;
  localparam int Q_SHIFT = 30;

  localparam logic signed [SUM_W-1:0] DOT_MAX = 67'sd2199023255551;
  localparam logic signed [SUM_W-1:0] DOT_MIN = -67'sd2199023255552;
  localparam logic [NORM_W-1:0]       NORM_MAX = {NORM_W{1'b1}};
  localparam logic [DIST_W-1:0]       ONE_Q14  = 16'd16384;
  localparam logic [DIST_W-1:0]       DIST_MAX = 16'd32768;
  localparam logic [RES_W-1:0]        RES_ONE  = 15'd16384;

  localparam logic [1:0] PQ_LAST_STEP  = 2'd3;
  localparam logic [1:0] TRY_LAST_STEP = 2'd2;

  typedef enum logic [2:0] {
    DEST_NONE,
    DEST_DOT,
    DEST_NA,
    DEST_NB,
    DEST_WIDE,
    DEST_T2
  } cds_dest_e;

  typedef struct packed {
    cds_dest_e  dest;
    logic [1:0] sh;     // product weight in limbs
  } cds_tag_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_AB,
    S_MUL_AA,
    S_MUL_BB,
    S_DRAIN,
    S_CHECK,
    S_P_MUL,
    S_P_LAND,
    S_P_SAVE,
    S_Q_MUL,
    S_Q_LAND,
    S_Q_SAVE,
    S_TRY_SQ,
    S_TRY_T2,
    S_TRY_MUL,
    S_TRY_LAND,
    S_TRY_CMP,
    S_FINISH
  } cds_state_e;

endpackage

@@ rtl/cds_mul.sv @@
// shared signed multiplier with registered product and destination tag
`timescale 1ns / 1ps
module cds_mul
  import cds_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [MUL_W-1:0]  op_x_i,
  input  logic signed [MUL_W-1:0]  op_y_i,
  input  cds_tag_t                 tag_i,
  output logic signed [PROD_W-1:0] prod_o,
  output cds_tag_t                 tag_o
);

  logic signed [PROD_W-1:0] prod_q;
  cds_tag_t                 tag_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_x_i * op_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{dest: DEST_NONE, sh: 2'd0};
    end else begin
      tag_q <= tag_i;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

@@ rtl/cosine_distance_stream.sv @@
// cosine distance stream: top level with accumulators and final sequencer
// an element pair not marked last steps through S_MUL_AB, S_MUL_AA and S_MUL_BB, input stalled
// a new pair is taken only once the last one is through; the three products share one 33x33 multiplier
// last pair: the distance follows the norm check, the wide products P and Q and
//   15 search trials on the shared multiplier; a zero norm skips straight to the result
// reset: rst_ni low clears the sequencer, accumulators and output valid at once
`timescale 1ns / 1ps
module cosine_distance_stream
  import cds_pkg::*;
#(
  parameter int ELEM_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // element pair input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ELEM_BITS-1:0] elem_a_i,
  input  logic signed [ELEM_BITS-1:0] elem_b_i,
  input  logic                        last_elem_i,
  // distance output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [DIST_W-1:0]           distance_o,
  output logic                        zero_norm_o
);

  // a norm below 1e-9 in real terms counts as zero
  localparam longint unsigned NormFloorL =
    ((64'd1 << (2 * ELEM_BITS - 2)) + 64'd999999999) / 64'd1000000000;
  localparam logic [NORM_W-1:0] NormFloor = NORM_W'(NormFloorL);

  cds_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;          // limb step inside a wide multiply
  logic [3:0] bit_q, bit_d;          // result bit under trial

  // accumulators, cleared by reset and after every result
  logic signed [DOT_W-1:0] dot_q, dot_d;
  logic [NORM_W-1:0]       na_q, na_d;
  logic [NORM_W-1:0]       nb_q, nb_d;

  // item and final-phase working registers
  logic signed [ELEM_BITS-1:0] a_q, a_d;
  logic signed [ELEM_BITS-1:0] b_q, b_d;
  logic                        last_q, last_d;
  logic [WIDE_W-1:0]           wacc_q, wacc_d;
  logic [P_W-1:0]              p_q, p_d;
  logic [WIDE_W-1:0]           q_q, q_d;
  logic [T2_W-1:0]             t2_q, t2_d;
  logic [RES_W-1:0]            c_q, c_d;
  logic                        zflag_q, zflag_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic              zero_q, zero_d;

  // shared multiplier
  logic signed [MUL_W-1:0]  op_x, op_y;
  cds_tag_t                 op_tag;
  logic signed [PROD_W-1:0] prod;
  cds_tag_t                 ptag;

  logic                    accept;
  logic                    slot_free;
  logic [DOT_W-1:0]        mag;
  logic [RES_W-1:0]        trial_m;
  logic                    m_ok;
  logic [RES_W:0]          t_val;
  logic signed [SUM_W-1:0] sum_dot;
  logic [SUM_W-1:0]        sum_na, sum_nb;
  logic [6:0]              sh_amt;
  logic [WIDE_W-1:0]       wide_add;

  cds_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_x_i (op_x),
    .op_y_i (op_y),
    .tag_i  (op_tag),
    .prod_o (prod),
    .tag_o  (ptag)
  );

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  // magnitude of the dot product, -2^41 maps to 2^41
  assign mag = dot_q[DOT_W-1] ? $unsigned(DOT_W'(-dot_q)) : $unsigned(dot_q);

  // bit-serial search: c is the largest m with P*(2m-1)^2 <= Q
  assign trial_m = c_q | (RES_W'(1) << bit_q);
  assign m_ok    = (trial_m <= RES_ONE);
  assign t_val   = {trial_m, 1'b0} - (RES_W + 1)'(1);

  // accumulate paths behind the multiplier register
  assign sum_dot  = SUM_W'(dot_q) + SUM_W'(prod);
  assign sum_na   = SUM_W'(na_q) + SUM_W'($unsigned(prod));
  assign sum_nb   = SUM_W'(nb_q) + SUM_W'($unsigned(prod));
  assign sh_amt   = 7'(ptag.sh) * 7'(LIMB_W);
  assign wide_add = wacc_q + (WIDE_W'(prod[2*LIMB_W-1:0]) << sh_amt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL_AB;
        end
      end
      S_MUL_AB: state_d = S_MUL_AA;
      S_MUL_AA: state_d = S_MUL_BB;
      // the b*b product lands in the cycle after, which only the final phase waits for
      S_MUL_BB: state_d = last_q ? S_DRAIN : S_IDLE;
      S_DRAIN:  state_d = S_CHECK;
      S_CHECK: begin
        if ((na_q < NormFloor) || (nb_q < NormFloor)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_P_MUL;
        end
      end
      S_P_MUL: begin
        if (cnt_q == PQ_LAST_STEP) begin
          state_d = S_P_LAND;
        end
      end
      S_P_LAND: state_d = S_P_SAVE;
      S_P_SAVE: state_d = S_Q_MUL;
      S_Q_MUL: begin
        if (cnt_q == PQ_LAST_STEP) begin
          state_d = S_Q_LAND;
        end
      end
      S_Q_LAND: state_d = S_Q_SAVE;
      S_Q_SAVE: state_d = S_TRY_SQ;
      S_TRY_SQ: state_d = S_TRY_T2;
      S_TRY_T2: state_d = S_TRY_MUL;
      S_TRY_MUL: begin
        if (cnt_q == TRY_LAST_STEP) begin
          state_d = S_TRY_LAND;
        end
      end
      S_TRY_LAND: state_d = S_TRY_CMP;
      S_TRY_CMP:  state_d = (bit_q == 4'd0) ? S_FINISH : S_TRY_SQ;
      S_FINISH: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier issue and datapath updates
  always_comb begin
    op_x        = '0;
    op_y        = '0;
    op_tag      = '{dest: DEST_NONE, sh: 2'd0};
    cnt_d       = 2'd0;
    bit_d       = bit_q;
    dot_d       = dot_q;
    na_d        = na_q;
    nb_d        = nb_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    wacc_d      = wacc_q;
    p_d         = p_q;
    q_d         = q_q;
    t2_d        = t2_q;
    c_d         = c_q;
    zflag_d     = zflag_q;
    dist_d      = dist_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (accept) begin
      a_d    = elem_a_i;
      b_d    = elem_b_i;
      last_d = last_elem_i;
    end

    // product landing from the previous cycle's issue
    case (ptag.dest)
      DEST_DOT: begin
        if (sum_dot > DOT_MAX) begin
          dot_d = DOT_MAX[DOT_W-1:0];
        end else if (sum_dot < DOT_MIN) begin
          dot_d = DOT_MIN[DOT_W-1:0];
        end else begin
          dot_d = sum_dot[DOT_W-1:0];
        end
      end
      DEST_NA:   na_d   = (sum_na > SUM_W'(NORM_MAX)) ? NORM_MAX : sum_na[NORM_W-1:0];
      DEST_NB:   nb_d   = (sum_nb > SUM_W'(NORM_MAX)) ? NORM_MAX : sum_nb[NORM_W-1:0];
      DEST_WIDE: wacc_d = wide_add;
      DEST_T2:   t2_d   = prod[T2_W-1:0];
      default: ;
    endcase

    unique case (state_q)
      S_MUL_AB: begin
        op_x   = MUL_W'(a_q);
        op_y   = MUL_W'(b_q);
        op_tag = '{dest: DEST_DOT, sh: 2'd0};
      end
      S_MUL_AA: begin
        op_x   = MUL_W'(a_q);
        op_y   = MUL_W'(a_q);
        op_tag = '{dest: DEST_NA, sh: 2'd0};
      end
      S_MUL_BB: begin
        op_x   = MUL_W'(b_q);
        op_y   = MUL_W'(b_q);
        op_tag = '{dest: DEST_NB, sh: 2'd0};
      end
      S_CHECK: begin
        zflag_d = (na_q < NormFloor) || (nb_q < NormFloor);
        c_d     = '0;
        wacc_d  = '0;
        bit_d   = 4'(RES_W - 1);
      end
      S_P_MUL: begin
        // low/high limbs of norm_a times norm_b
        op_x   = cnt_q[0] ? MUL_W'(na_q[NORM_W-1:LIMB_W]) : MUL_W'(na_q[LIMB_W-1:0]);
        op_y   = cnt_q[1] ? MUL_W'(nb_q[NORM_W-1:LIMB_W]) : MUL_W'(nb_q[LIMB_W-1:0]);
        op_tag = '{dest: DEST_WIDE, sh: 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})};
        cnt_d  = cnt_q + 2'd1;
      end
      S_P_SAVE: begin
        p_d    = wacc_q[P_W-1:0];
        wacc_d = '0;
      end
      S_Q_MUL: begin
        // |dot| squared, same limb walk
        op_x   = cnt_q[0] ? MUL_W'(mag[DOT_W-1:LIMB_W]) : MUL_W'(mag[LIMB_W-1:0]);
        op_y   = cnt_q[1] ? MUL_W'(mag[DOT_W-1:LIMB_W]) : MUL_W'(mag[LIMB_W-1:0]);
        op_tag = '{dest: DEST_WIDE, sh: 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})};
        cnt_d  = cnt_q + 2'd1;
      end
      S_Q_SAVE: begin
        q_d    = wacc_q << Q_SHIFT;
        wacc_d = '0;
      end
      S_TRY_SQ: begin
        op_x   = MUL_W'(t_val);
        op_y   = MUL_W'(t_val);
        op_tag = '{dest: DEST_T2, sh: 2'd0};
      end
      S_TRY_MUL: begin
        case (cnt_q)
          2'd0:    op_x = MUL_W'(p_q[LIMB_W-1:0]);
          2'd1:    op_x = MUL_W'(p_q[2*LIMB_W-1:LIMB_W]);
          default: op_x = MUL_W'(p_q[P_W-1:2*LIMB_W]);
        endcase
        op_y   = MUL_W'(t2_q);
        op_tag = '{dest: DEST_WIDE, sh: cnt_q};
        cnt_d  = (cnt_q == TRY_LAST_STEP) ? 2'd0 : cnt_q + 2'd1;
      end
      S_TRY_CMP: begin
        if (m_ok && (wacc_q <= q_q)) begin
          c_d = trial_m;
        end
        wacc_d = '0;
        if (bit_q != 4'd0) begin
          bit_d = bit_q - 4'd1;
        end
      end
      S_FINISH: begin
        // load the output register once the previous result has left
        if (slot_free) begin
          if (zflag_q) begin
            dist_d = ONE_Q14;
          end else if (dot_q[DOT_W-1]) begin
            dist_d = ONE_Q14 + DIST_W'(c_q);
          end else begin
            dist_d = ONE_Q14 - DIST_W'(c_q);
          end
          zero_d      = zflag_q;
          out_valid_d = 1'b1;
          dot_d       = '0;
          na_d        = '0;
          nb_d        = '0;
        end
      end
      default: ;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 2'd0;
      bit_q       <= 4'd0;
      dot_q       <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      dot_q       <= dot_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    last_q  <= last_d;
    wacc_q  <= wacc_d;
    p_q     <= p_d;
    q_q     <= q_d;
    t2_q    <= t2_d;
    c_q     <= c_d;
    zflag_q <= zflag_d;
    dist_q  <= dist_d;
    zero_q  <= zero_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign zero_norm_o = zero_q;

endmodule

@@ rtl/cds_checker.sv @@
// port-level assertions for the cosine distance stream, bound to the top level
`timescale 1ns / 1ps
`include "cosine_distance_stream_defines.svh"
module cds_checker
  import cds_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DIST_W-1:0] distance_o,
  input logic              zero_norm_o
);

  `CDS_ASSERT_IMP(a_dist_range, out_valid_o, distance_o <= DIST_MAX, "distance above 2.0")
  `CDS_ASSERT_IMP(a_zero_is_one, out_valid_o && zero_norm_o, distance_o == ONE_Q14, "zero norm not 1.0")
  `CDS_ASSERT_NXT(a_busy_after_xfer, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after transfer")
  `CDS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(distance_o) && $stable(zero_norm_o), "stalled result changed")

endmodule

bind cosine_distance_stream cds_checker u_cds_checker (.*);
